### design/qpr_pkg.sv
// shared types, constants and register codes for the reprojection residual core
package qpr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CAM_W = 36;
    localparam int NORM_W = 63;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 31;

    localparam logic [CFG_AW-1:0] REG_OFFSET_MODE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_FOCAL_X = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FOCAL_Y = 3'd2;
    localparam logic [CFG_AW-1:0] REG_CENTER_X = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CENTER_Y = 3'd4;

    localparam logic [30:0] FOCAL_RST = 31'd65536000;

    typedef struct packed {
        logic [28:0] obs_u;
        logic [28:0] obs_v;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] quat_w;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] resid_u;
        logic signed [31:0] resid_v;
        logic bad_depth;
    } result_t;

    typedef struct packed {
        logic offset_mode;
        logic [30:0] focal_x;
        logic [30:0] focal_y;
        logic [28:0] center_x;
        logic [28:0] center_y;
    } cfg_t;

    // row-major rotation matrix, entry 3*i+j, signed q2.30
    typedef logic [8:0][31:0] mat_t;

    typedef struct packed {
        item_t item;
        logic nzero;
        logic [8:0] neg;
        logic [8:0] sat;
    } rm_side_t;

    typedef struct packed {
        logic bad;
        logic neg_u;
        logic neg_v;
        logic [CAM_W-1:0] mag_u;
        logic [CAM_W-1:0] mag_v;
        logic [CAM_W-1:0] depth;
        logic [28:0] obs_u;
        logic [28:0] obs_v;
    } rt_out_t;

    typedef struct packed {
        logic bad;
        logic neg_u;
        logic neg_v;
        logic [28:0] obs_u;
        logic [28:0] obs_v;
    } pj_side_t;

endpackage

### design/qpr_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, shared divisor over lanes
module qpr_div_pipe #(
    parameter int LANES = 1,
    parameter int QW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic src_valid,
    input  logic [DW-1:0] d,
    input  logic [DW-1:0] hi [LANES],
    input  logic [QW-1:0] lo [LANES],
    input  logic [SW-1:0] src_side,
    output logic dst_valid,
    output logic [QW-1:0] quo [LANES],
    output logic [SW-1:0] dst_side
);

    logic [QW-1:0] valid_reg;
    logic [DW-1:0] d_reg [QW];
    logic [SW-1:0] side_reg [QW];
    logic [DW-1:0] rem_reg [QW][LANES];
    logic [QW-1:0] word_reg [QW][LANES];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic vld_src;
        logic [DW-1:0] d_src;
        logic [SW-1:0] side_src;
        logic [DW-1:0] rem_src [LANES];
        logic [QW-1:0] word_src [LANES];
        logic [DW-1:0] rem_next [LANES];
        logic [QW-1:0] word_next [LANES];

        if (k == 0) begin : g_first
            assign vld_src = src_valid;
            assign d_src = d;
            assign side_src = src_side;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_src[l] = hi[l];
                assign word_src[l] = lo[l];
            end
        end
        else begin : g_rest
            assign vld_src = valid_reg[k-1];
            assign d_src = d_reg[k-1];
            assign side_src = side_reg[k-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_src[l] = rem_reg[k-1][l];
                assign word_src[l] = word_reg[k-1][l];
            end
        end

        always_comb
        begin
            logic [DW:0] trial;
            logic ge;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_src[l], word_src[l][QW-1]};
                ge = (trial >= {1'b0, d_src});
                rem_next[l] = ge ? DW'(trial - {1'b0, d_src}) : trial[DW-1:0];
                word_next[l] = {word_src[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= d_src;
                side_reg[k] <= side_src;
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[l];
                    word_reg[k][l] <= word_next[l];
                end
            end
        end
    end

    assign dst_valid = valid_reg[QW-1];
    assign dst_side = side_reg[QW-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign quo[l] = word_reg[QW-1][l];
    end

endmodule

### design/qpr_rotmat.sv
// quaternion to normalised rotation matrix: products, norm, numerators, divides
module qpr_rotmat (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic src_valid,
    input  qpr_pkg::item_t src_item,
    output logic dst_valid,
    output qpr_pkg::mat_t mat,
    output qpr_pkg::item_t dst_item,
    output logic nzero
);
    import qpr_pkg::*;

    localparam int NP = 10;
    localparam int NM = 9;
    localparam int QW = 31;
    localparam int DW = NORM_W;

    function automatic logic signed [61:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[63:2];
    endfunction

    // products: ww xx yy zz xy xz yz wx wy wz
    logic s1_valid_reg;
    logic signed [61:0] pr_reg [NP];
    logic signed [61:0] pr_next [NP];
    item_t s1_item_reg;

    logic s2_valid_reg;
    logic signed [63:0] num_reg [NM];
    logic signed [63:0] num_next [NM];
    logic [DW-1:0] n2_reg;
    logic [DW-1:0] n2_next;
    item_t s2_item_reg;

    logic s3_valid_reg;
    logic [NM-1:0] neg3_reg;
    logic [62:0] mag3_reg [NM];
    logic [DW-1:0] n3_reg;
    logic nz3_reg;
    item_t s3_item_reg;

    logic s4_valid_reg;
    logic [DW-1:0] hi4_reg [NM];
    logic [QW-1:0] lo4_reg [NM];
    logic [NM-1:0] neg4_reg;
    logic [NM-1:0] sat4_reg;
    logic [DW-1:0] n4_reg;
    logic nz4_reg;
    item_t s4_item_reg;

    rm_side_t div_side_in;
    rm_side_t div_side_out;
    logic div_valid;
    logic [QW-1:0] div_quo [NM];

    logic s5_valid_reg;
    mat_t mat_reg;
    mat_t mat_next;
    item_t s5_item_reg;
    logic nz5_reg;

    always_comb
    begin
        pr_next[0] = qmul(src_item.quat_w, src_item.quat_w);
        pr_next[1] = qmul(src_item.quat_x, src_item.quat_x);
        pr_next[2] = qmul(src_item.quat_y, src_item.quat_y);
        pr_next[3] = qmul(src_item.quat_z, src_item.quat_z);
        pr_next[4] = qmul(src_item.quat_x, src_item.quat_y);
        pr_next[5] = qmul(src_item.quat_x, src_item.quat_z);
        pr_next[6] = qmul(src_item.quat_y, src_item.quat_z);
        pr_next[7] = qmul(src_item.quat_w, src_item.quat_x);
        pr_next[8] = qmul(src_item.quat_w, src_item.quat_y);
        pr_next[9] = qmul(src_item.quat_w, src_item.quat_z);
    end

    always_comb
    begin
        logic signed [63:0] e [NP];
        logic signed [63:0] nsum;
        for (int k = 0; k < NP; k++)
            e[k] = 64'(pr_reg[k]);
        nsum = e[0] + e[1] + e[2] + e[3];
        n2_next = nsum[DW-1:0];
        num_next[0] = e[0] + e[1] - e[2] - e[3];
        num_next[1] = (e[4] - e[9]) <<< 1;
        num_next[2] = (e[5] + e[8]) <<< 1;
        num_next[3] = (e[4] + e[9]) <<< 1;
        num_next[4] = e[0] - e[1] + e[2] - e[3];
        num_next[5] = (e[6] - e[7]) <<< 1;
        num_next[6] = (e[5] - e[8]) <<< 1;
        num_next[7] = (e[6] + e[7]) <<< 1;
        num_next[8] = e[0] - e[1] - e[2] + e[3];
    end

    always_comb
    begin
        for (int k = 0; k < NM; k++)
        begin
            mat_next[k] = div_side_out.sat[k] ? 32'h7FFF_FFFF : {1'b0, div_quo[k]};
            if (div_side_out.neg[k])
                mat_next[k] = 32'(-mat_next[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= src_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg <= pr_next;
            s1_item_reg <= src_item;

            num_reg <= num_next;
            n2_reg <= n2_next;
            s2_item_reg <= s1_item_reg;

            for (int k = 0; k < NM; k++)
            begin
                neg3_reg[k] <= num_reg[k][63];
                mag3_reg[k] <= num_reg[k][63] ? 63'(-num_reg[k]) : num_reg[k][62:0];
            end
            n3_reg <= n2_reg;
            nz3_reg <= (n2_reg == '0);
            s3_item_reg <= s2_item_reg;

            for (int k = 0; k < NM; k++)
            begin
                sat4_reg[k] <= ({1'b0, mag3_reg[k]} >= {n3_reg, 1'b0});
                hi4_reg[k] <= {1'b0, mag3_reg[k][62:1]};
                lo4_reg[k] <= {mag3_reg[k][0], {(QW-1){1'b0}}};
            end
            neg4_reg <= neg3_reg;
            n4_reg <= n3_reg;
            nz4_reg <= nz3_reg;
            s4_item_reg <= s3_item_reg;

            mat_reg <= mat_next;
            s5_item_reg <= div_side_out.item;
            nz5_reg <= div_side_out.nzero;
        end
    end

    assign div_side_in = '{item: s4_item_reg, nzero: nz4_reg, neg: neg4_reg, sat: sat4_reg};

    qpr_div_pipe #(
        .LANES (NM),
        .QW    (QW),
        .DW    (DW),
        .SW    ($bits(rm_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (s4_valid_reg),
        .d         (n4_reg),
        .hi        (hi4_reg),
        .lo        (lo4_reg),
        .src_side  (div_side_in),
        .dst_valid (div_valid),
        .quo       (div_quo),
        .dst_side  (div_side_out)
    );

    assign dst_valid = s5_valid_reg;
    assign mat = mat_reg;
    assign dst_item = s5_item_reg;
    assign nzero = nz5_reg;

endmodule

### design/qpr_rotate.sv
// offset and rotation of the point into the camera frame, depth check
module qpr_rotate (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic mode,
    input  logic src_valid,
    input  qpr_pkg::mat_t mat,
    input  qpr_pkg::item_t src_item,
    input  logic nzero,
    output logic dst_valid,
    output qpr_pkg::rt_out_t dst
);
    import qpr_pkg::*;

    logic r1_valid_reg;
    logic signed [32:0] v_reg [3];
    logic signed [32:0] v_next [3];
    mat_t m1_reg;
    logic signed [31:0] off1_reg [3];
    logic [28:0] ou1_reg;
    logic [28:0] ov1_reg;
    logic nz1_reg;

    logic r2_valid_reg;
    logic signed [64:0] prod_reg [9];
    logic signed [64:0] prod_next [9];
    logic signed [31:0] off2_reg [3];
    logic [28:0] ou2_reg;
    logic [28:0] ov2_reg;
    logic nz2_reg;

    logic r3_valid_reg;
    logic signed [CAM_W-1:0] cam_reg [3];
    logic signed [CAM_W-1:0] cam_next [3];
    logic [28:0] ou3_reg;
    logic [28:0] ov3_reg;
    logic nz3_reg;

    logic r4_valid_reg;
    rt_out_t dst_reg;
    rt_out_t dst_next;

    logic signed [31:0] pt [3];
    logic signed [31:0] of [3];

    assign pt[0] = src_item.point_x;
    assign pt[1] = src_item.point_y;
    assign pt[2] = src_item.point_z;
    assign of[0] = src_item.offset_x;
    assign of[1] = src_item.offset_y;
    assign of[2] = src_item.offset_z;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            v_next[j] = mode ? 33'(pt[j]) - 33'(of[j]) : 33'(pt[j]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                prod_next[3*i+j] = 65'($signed(m1_reg[3*i+j])) * 65'(v_reg[j]);
    end

    always_comb
    begin
        logic signed [36:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            acc = mode ? 37'sd0 : 37'(off2_reg[i]);
            for (int j = 0; j < 3; j++)
                acc = acc + 37'(prod_reg[3*i+j] >>> 30);
            cam_next[i] = acc[CAM_W-1:0];
        end
    end

    always_comb
    begin
        dst_next.bad = nz3_reg || (cam_reg[2] <= 0);
        dst_next.neg_u = cam_reg[0][CAM_W-1];
        dst_next.neg_v = cam_reg[1][CAM_W-1];
        dst_next.mag_u = cam_reg[0][CAM_W-1] ? CAM_W'(-cam_reg[0]) : cam_reg[0];
        dst_next.mag_v = cam_reg[1][CAM_W-1] ? CAM_W'(-cam_reg[1]) : cam_reg[1];
        dst_next.depth = cam_reg[2];
        dst_next.obs_u = ou3_reg;
        dst_next.obs_v = ov3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            r3_valid_reg <= 1'b0;
            r4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_valid_reg <= src_valid;
            r2_valid_reg <= r1_valid_reg;
            r3_valid_reg <= r2_valid_reg;
            r4_valid_reg <= r3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            m1_reg <= mat;
            off1_reg <= of;
            ou1_reg <= src_item.obs_u;
            ov1_reg <= src_item.obs_v;
            nz1_reg <= nzero;

            prod_reg <= prod_next;
            off2_reg <= off1_reg;
            ou2_reg <= ou1_reg;
            ov2_reg <= ov1_reg;
            nz2_reg <= nz1_reg;

            cam_reg <= cam_next;
            ou3_reg <= ou2_reg;
            ov3_reg <= ov2_reg;
            nz3_reg <= nz2_reg;

            dst_reg <= dst_next;
        end
    end

    assign dst_valid = r4_valid_reg;
    assign dst = dst_reg;

endmodule

### design/qpr_project.sv
// perspective divide, focal scaling, principal point and residual saturation
module qpr_project #(
    parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  qpr_pkg::cfg_t cfg,
    input  logic src_valid,
    input  qpr_pkg::rt_out_t src,
    output logic dst_valid,
    output qpr_pkg::result_t dst
);
    import qpr_pkg::*;

    localparam int QW = CAM_W + FRAC_BITS;
    localparam int QH = QW - 32;
    localparam int PW = 31 + QW;
    localparam int HW = 31 + QH;
    localparam int TM_W = 34;
    localparam logic [TM_W-1:0] TM_MAX = TM_W'(1) << 33;
    localparam logic signed [36:0] S_MAX = 37'sd2147483647;
    localparam logic signed [36:0] S_MIN = -37'sd2147483648;

    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        if (v > S_MAX)
            return 32'h7FFF_FFFF;
        else if (v < S_MIN)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    logic [CAM_W-1:0] div_hi [2];
    logic [QW-1:0] div_lo [2];
    logic [QW-1:0] div_quo [2];
    logic div_valid;
    pj_side_t side_in;
    pj_side_t side_out;

    logic [30:0] f [2];
    logic [28:0] c [2];

    logic p1_valid_reg;
    logic [62:0] plo1_reg [2];
    logic [QH-1:0] qhi1_reg [2];
    pj_side_t side1_reg;

    logic p2_valid_reg;
    logic [62:0] plo2_reg [2];
    logic [HW-1:0] phi2_reg [2];
    pj_side_t side2_reg;

    logic p3_valid_reg;
    logic [TM_W-1:0] tm3_reg [2];
    logic [TM_W-1:0] tm3_next [2];
    pj_side_t side3_reg;

    logic p4_valid_reg;
    logic signed [36:0] s4_reg [2];
    logic signed [36:0] s4_next [2];
    logic bad4_reg;

    logic p5_valid_reg;
    result_t dst_reg;

    assign f[0] = cfg.focal_x;
    assign f[1] = cfg.focal_y;
    assign c[0] = cfg.center_x;
    assign c[1] = cfg.center_y;

    assign div_hi[0] = '0;
    assign div_hi[1] = '0;
    assign div_lo[0] = {src.mag_u, {FRAC_BITS{1'b0}}};
    assign div_lo[1] = {src.mag_v, {FRAC_BITS{1'b0}}};
    assign side_in = '{bad: src.bad, neg_u: src.neg_u, neg_v: src.neg_v,
                       obs_u: src.obs_u, obs_v: src.obs_v};

    qpr_div_pipe #(
        .LANES (2),
        .QW    (QW),
        .DW    (CAM_W),
        .SW    ($bits(pj_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (src_valid),
        .d         (src.depth),
        .hi        (div_hi),
        .lo        (div_lo),
        .src_side  (side_in),
        .dst_valid (div_valid),
        .quo       (div_quo),
        .dst_side  (side_out)
    );

    always_comb
    begin
        logic [PW-1:0] full;
        for (int l = 0; l < 2; l++)
        begin
            full = PW'(plo2_reg[l]) + (PW'(phi2_reg[l]) << 32);
            // anything past 2^33 saturates the residual anyway
            if (|full[PW-1:FRAC_BITS+33])
                tm3_next[l] = TM_MAX;
            else
                tm3_next[l] = {1'b0, full[FRAC_BITS+32:FRAC_BITS]};
        end
    end

    always_comb
    begin
        logic signed [34:0] term;
        logic neg;
        logic [28:0] obs;
        for (int l = 0; l < 2; l++)
        begin
            neg = (l == 0) ? side3_reg.neg_u : side3_reg.neg_v;
            obs = (l == 0) ? side3_reg.obs_u : side3_reg.obs_v;
            term = neg ? 35'(-{1'b0, tm3_reg[l]}) : {1'b0, tm3_reg[l]};
            s4_next[l] = 37'(term) + 37'(c[l]) - 37'(obs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= div_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                plo1_reg[l] <= 63'(f[l]) * 63'(div_quo[l][31:0]);
                qhi1_reg[l] <= div_quo[l][QW-1:32];
                plo2_reg[l] <= plo1_reg[l];
                phi2_reg[l] <= HW'(f[l]) * HW'(qhi1_reg[l]);
            end
            side1_reg <= side_out;
            side2_reg <= side1_reg;

            tm3_reg <= tm3_next;
            side3_reg <= side2_reg;

            s4_reg <= s4_next;
            bad4_reg <= side3_reg.bad;

            dst_reg.resid_u <= bad4_reg ? 32'sd0 : sat32(s4_reg[0]);
            dst_reg.resid_v <= bad4_reg ? 32'sd0 : sat32(s4_reg[1]);
            dst_reg.bad_depth <= bad4_reg;
        end
    end

    assign dst_valid = p5_valid_reg;
    assign dst = dst_reg;

endmodule

### design/quat_pinhole_reprojection_residual_core.sv
// top level of the quaternion pinhole reprojection residual core
// One transaction in and one out per cycle when neither side stalls. Most stages between
// acceptance and resid_valid are in the two bit-per-stage dividers, which have 31 stages
// for the matrix normalisation and 36 + FRAC_BITS stages for the perspective divide.
// A stall at the output freezes the whole pipeline only once the last stage holds a
// result, so empty slots keep draining in while a finished result waits.
// Configuration writes take effect at once and must be made with the pipeline empty.
module quat_pinhole_reprojection_residual_core #(
    parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  qpr_pkg::item_t item,
    output logic resid_valid,
    input  logic resid_ready,
    output qpr_pkg::result_t resid,
    input  logic cfg_we,
    input  logic [qpr_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [qpr_pkg::CFG_DW-1:0] cfg_wdata
);
    import qpr_pkg::*;

    cfg_t cfg_reg;
    logic en;

    logic rm_valid;
    mat_t rm_mat;
    item_t rm_item;
    logic rm_nzero;

    logic rt_valid;
    rt_out_t rt_out;

    logic pj_valid;
    result_t pj_out;

    logic out_valid_reg;
    result_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_mode <= 1'b0;
            cfg_reg.focal_x <= FOCAL_RST;
            cfg_reg.focal_y <= FOCAL_RST;
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_OFFSET_MODE: cfg_reg.offset_mode <= cfg_wdata[0];
                REG_FOCAL_X:     cfg_reg.focal_x <= cfg_wdata[30:0];
                REG_FOCAL_Y:     cfg_reg.focal_y <= cfg_wdata[30:0];
                REG_CENTER_X:    cfg_reg.center_x <= cfg_wdata[28:0];
                REG_CENTER_Y:    cfg_reg.center_y <= cfg_wdata[28:0];
                default:         ;
            endcase
        end
    end

    assign en = !pj_valid || !out_valid_reg || resid_ready;
    assign item_ready = en;

    qpr_rotmat u_rotmat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .src_valid (item_valid),
        .src_item  (item),
        .dst_valid (rm_valid),
        .mat       (rm_mat),
        .dst_item  (rm_item),
        .nzero     (rm_nzero)
    );

    qpr_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (cfg_reg.offset_mode),
        .src_valid (rm_valid),
        .mat       (rm_mat),
        .src_item  (rm_item),
        .nzero     (rm_nzero),
        .dst_valid (rt_valid),
        .dst       (rt_out)
    );

    qpr_project #(
        .FRAC_BITS (FRAC_BITS)
    ) u_project (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .src_valid (rt_valid),
        .src       (rt_out),
        .dst_valid (pj_valid),
        .dst       (pj_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || resid_ready)
            out_valid_reg <= pj_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || resid_ready)
            out_reg <= pj_out;
    end

    assign resid_valid = out_valid_reg;
    assign resid = out_reg;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        resid_valid && resid.bad_depth |-> resid.resid_u == 0 && resid.resid_v == 0)
        else $error("flagged transaction with non-zero residual");

    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pj_valid && !en |=> pj_valid)
        else $error("pipeline tail lost a result while stalled");

    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        pj_valid && resid_valid && !resid_ready |-> !item_ready)
        else $error("transaction accepted with full pipeline tail");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !pj_valid |-> item_ready)
        else $error("input blocked with empty pipeline tail");
`endif

endmodule
